// ----- rtl/protection_chip_register_file_unit_assert.svh -----
// Assertion macros shared by the register file unit RTL.
`ifndef PROTECTION_CHIP_REGISTER_FILE_UNIT_ASSERT_SVH
`define PROTECTION_CHIP_REGISTER_FILE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pcrf_pkg.sv -----
// Types, constants and functions of the protection chip register file.
package pcrf_pkg;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 16;
    localparam int IDX_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int REGION_W = 3;
    localparam int FLAG_W   = 4;

    // Bus command codes.
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Register indexes with a write or read action.
    localparam logic [IDX_W-1:0] IDX_LATCH0 = 8'h00;
    localparam logic [IDX_W-1:0] IDX_LATCH1 = 8'h01;
    localparam logic [IDX_W-1:0] IDX_LATCH2 = 8'h02;
    localparam logic [IDX_W-1:0] IDX_SCRBYTE = 8'h03;
    localparam logic [IDX_W-1:0] IDX_SHIFT  = 8'h40;
    localparam logic [IDX_W-1:0] IDX_FLAGS  = 8'h48;
    localparam logic [IDX_W-1:0] IDX_STEP   = 8'h80;
    localparam logic [IDX_W-1:0] IDX_STEP_MASK = 8'hf8;
    localparam logic [IDX_W-1:0] IDX_CLEAR  = 8'ha0;

    localparam logic [DATA_W-1:0] SCR_XOR   = 16'h2bad;
    localparam logic [DATA_W-1:0] FLAG_M0   = 16'h0090;
    localparam logic [DATA_W-1:0] FLAG_M1   = 16'h0006;
    localparam logic [DATA_W-1:0] FLAG_M2   = 16'h9000;
    localparam logic [DATA_W-1:0] FLAG_M3   = 16'h0a00;

    // Scrambler feedback modes.
    typedef enum logic [1:0] {
        MODE_1,
        MODE_2,
        MODE_3,
        MODE_4
    } pcrf_mode_t;

    // One operation handed from the input stage to the register core.
    typedef struct packed {
        logic              go;
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data;
    } pcrf_op_t;

    function automatic pcrf_mode_t mode_of(input logic [REGION_W-1:0] region);
        pcrf_mode_t m;
        unique case (region)
            3'd0, 3'd1: m = MODE_1;
            3'd2:       m = MODE_3;
            3'd3:       m = MODE_2;
            default:    m = MODE_4;
        endcase
        return m;
    endfunction

    // One scrambler step: rotate, fixed xor, data bit and mode feedback.
    function automatic logic [DATA_W-1:0] scramble(
        input logic [DATA_W-1:0]   old,
        input logic [FLAG_W-1:0]   f,
        input logic [REGION_W-1:0] region,
        input logic [DATA_W-1:0]   data,
        input logic [2:0]          sel
    );
        logic [DATA_W-1:0] h;
        h = {old[DATA_W-2:0], old[DATA_W-1]} ^ SCR_XOR;
        h[0]  = h[0] ^ data[sel] ^ old[5];
        h[10] = h[10] ^ f[2];
        unique case (mode_of(region))
            MODE_1:
            begin
                h[0]  = h[0] ^ old[10] ^ old[8];
                h[1]  = h[1] ^ f[0];
                h[6]  = h[6] ^ f[1];
                h[14] = h[14] ^ f[3];
            end
            MODE_2:
            begin
                h[0]  = h[0] ^ old[7] ^ old[6];
                h[4]  = h[4] ^ f[0];
                h[6]  = h[6] ^ f[1];
                h[12] = h[12] ^ f[3];
            end
            MODE_3:
            begin
                h[0]  = h[0] ^ old[10] ^ old[8];
                h[4]  = h[4] ^ f[0];
                h[6]  = h[6] ^ f[1];
                h[12] = h[12] ^ f[3];
            end
            MODE_4:
            begin
                h[0]  = h[0] ^ old[7] ^ old[6];
                h[3]  = h[3] ^ f[0];
                h[8]  = h[8] ^ f[1];
                h[14] = h[14] ^ f[3];
            end
        endcase
        return h;
    endfunction

    // Fixed identity bytes; every unlisted index reads zero.
    function automatic logic [BYTE_W-1:0] ident_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            8'h20: b = 8'h49;
            8'h21: b = 8'h47;
            8'h22: b = 8'h53;
            8'h24: b = 8'h41;
            8'h25: b = 8'h41;
            8'h26: b = 8'h7f;
            8'h27: b = 8'h41;
            8'h28: b = 8'h41;
            8'h2a: b = 8'h3e;
            8'h2b: b = 8'h41;
            8'h2c: b = 8'h49;
            8'h2d: b = 8'hf9;
            8'h2e: b = 8'h0a;
            8'h30: b = 8'h26;
            8'h31: b = 8'h49;
            8'h32: b = 8'h49;
            8'h33: b = 8'h49;
            8'h34: b = 8'h32;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/pcrf_if.sv -----
// Valid/ready channel interfaces for bus commands and read bytes.
interface pcrf_cmd_if;
    import pcrf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data;

    modport source (output valid, output command, output data, input ready);
    modport sink (input valid, input command, input data, output ready);
endinterface

interface pcrf_rd_if;
    import pcrf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

// ----- rtl/protection_chip_register_file_unit.sv -----
// Top level of the protection chip register file: input stage, core, read register.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------
//  cmd     | in  | valid/ready   | command[1:0], data[15:0]
//  rsp     | out | valid/ready   | read_data[7:0] (reads only)
//  cfg     | in  | cfg_we        | cfg_wdata[2:0] -> region
//
// One transfer per cycle is accepted while the input register can advance; a read
// passes from cmd into the input register, then through the core into the read register.
// Selects and writes never wait on rsp; a read waits in the input register
// while the read register still holds an untaken byte.
// Reset clears the chip state, the valid flags and the region; payload registers are not reset.
module protection_chip_register_file_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    pcrf_cmd_if.sink                      cmd,
    pcrf_rd_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [pcrf_pkg::REGION_W-1:0] cfg_wdata
);
    import pcrf_pkg::*;

    logic [REGION_W-1:0] region_reg;
    logic                s1_valid_reg;
    logic [CMD_W-1:0]    s1_cmd_reg;
    logic [DATA_W-1:0]   s1_data_reg;
    logic                rsp_valid_reg;
    logic [BYTE_W-1:0]   rsp_data_reg;

    logic                s1_is_read;
    logic                s1_go;
    pcrf_op_t            op;
    logic [BYTE_W-1:0]   rd_byte;

    // Region configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            region_reg <= '0;
        else if (cfg_we)
            region_reg <= cfg_wdata;
    end

    // Stage advance: reads need a free read register.
    always_comb
    begin
        s1_is_read = s1_cmd_reg == CMD_READ;
        s1_go      = s1_valid_reg && (!s1_is_read || !rsp_valid_reg || rsp.ready);
        op.go      = s1_go;
        op.command = s1_cmd_reg;
        op.data    = s1_data_reg;
    end

    assign cmd.ready = !s1_valid_reg || s1_go;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cmd.ready)
            s1_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_cmd_reg  <= cmd.command;
            s1_data_reg <= cmd.data;
        end
    end

    pcrf_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .region  (region_reg),
        .op      (op),
        .rd_byte (rd_byte)
    );

    // Read result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (s1_go && s1_is_read)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_is_read)
            rsp_data_reg <= rd_byte;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

    `include "protection_chip_register_file_unit_assert.svh"

    // Anything but a read leaves the input register at once.
    `PCRF_ASSERT_IMP(a_nonread_go, clk, rst_n, s1_valid_reg && !s1_is_read, s1_go,
        "non-read command stalled")
    // A blocked read stays in the input register unchanged.
    `PCRF_ASSERT_NXT(a_read_hold, clk, rst_n,
        s1_valid_reg && s1_is_read && rsp_valid_reg && !rsp.ready,
        s1_valid_reg && s1_is_read && $stable(s1_data_reg), "blocked read lost")
    // A new read byte only appears after a read left the input register.
    `PCRF_ASSERT_IMP(a_rsp_source, clk, rst_n, $rose(rsp_valid_reg),
        $past(s1_go && s1_is_read), "read byte without read command")

endmodule

// ----- rtl/pcrf_core.sv -----
// Register state of the protection chip and its read multiplexer.
module pcrf_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pcrf_pkg::REGION_W-1:0] region,
    input  pcrf_pkg::pcrf_op_t         op,
    output logic [pcrf_pkg::BYTE_W-1:0]   rd_byte
);
    import pcrf_pkg::*;

    logic [IDX_W-1:0]  sel_idx_reg;
    logic [BYTE_W-1:0] latch0_reg;
    logic [BYTE_W-1:0] latch1_reg;
    logic [BYTE_W-1:0] latch2_reg;
    logic [DATA_W-1:0] pair_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [DATA_W-1:0] scr_reg;

    logic              do_select;
    logic              do_write;
    logic [BYTE_W-1:0] latch_next;
    logic [DATA_W-1:0] pair_next;
    logic [FLAG_W-1:0] flags_next;
    logic [DATA_W-1:0] scr_next;

    // Decode the operation and form the candidate next values.
    always_comb
    begin
        do_select  = op.go && (op.command == CMD_SELECT);
        do_write   = op.go && (op.command == CMD_WRITE);
        latch_next = {op.data[BYTE_W-2:0], 1'b0};
        pair_next  = {pair_reg[BYTE_W-1:0], {BYTE_W{1'b0}}} | op.data;
        flags_next[0] = (pair_reg & FLAG_M0) == '0;
        flags_next[1] = (pair_reg & FLAG_M1) == '0;
        flags_next[2] = (pair_reg & FLAG_M2) == '0;
        flags_next[3] = (pair_reg & FLAG_M3) == '0;
        scr_next   = scramble(scr_reg, flags_reg, region, op.data, sel_idx_reg[2:0]);
    end

    // State update for selects and writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_idx_reg <= '0;
            latch0_reg  <= '0;
            latch1_reg  <= '0;
            latch2_reg  <= '0;
            pair_reg    <= '0;
            flags_reg   <= '0;
            scr_reg     <= '0;
        end
        else if (do_select)
        begin
            sel_idx_reg <= op.data[IDX_W-1:0];
        end
        else if (do_write)
        begin
            priority if (sel_idx_reg == IDX_LATCH0)
                latch0_reg <= latch_next;
            else if (sel_idx_reg == IDX_LATCH1)
                latch1_reg <= latch_next;
            else if (sel_idx_reg == IDX_LATCH2)
                latch2_reg <= latch_next;
            else if (sel_idx_reg == IDX_SHIFT)
                pair_reg <= pair_next;
            else if (sel_idx_reg == IDX_FLAGS)
                flags_reg <= flags_next;
            else if ((sel_idx_reg & IDX_STEP_MASK) == IDX_STEP)
                scr_reg <= scr_next;
            else if (sel_idx_reg == IDX_CLEAR)
                scr_reg <= '0;
            else
                scr_reg <= scr_reg;
        end
    end

    // Read multiplexer over the current state.
    always_comb
    begin
        unique case (sel_idx_reg)
            IDX_LATCH0:  rd_byte = {latch0_reg[7:4], region[0], latch0_reg[2:0]};
            IDX_LATCH1:  rd_byte = latch1_reg;
            IDX_LATCH2:  rd_byte = {region[1], latch2_reg[6:0]};
            IDX_SCRBYTE: rd_byte = {scr_reg[5], scr_reg[2], scr_reg[9], scr_reg[7],
                                    scr_reg[10], scr_reg[13], scr_reg[12], scr_reg[15]};
            default:     rd_byte = ident_byte(sel_idx_reg);
        endcase
    end

    `include "protection_chip_register_file_unit_assert.svh"

    // A clear write leaves the scrambler at zero.
    `PCRF_ASSERT_NXT(a_clear_zero, clk, rst_n,
        do_write && (sel_idx_reg == IDX_CLEAR), scr_reg == '0, "scrambler not cleared")
    // The selected index only moves on a select transfer.
    `PCRF_ASSERT_NXT(a_sel_hold, clk, rst_n, !do_select, $stable(sel_idx_reg),
        "index changed without select")

endmodule

// ----- tb/protection_chip_register_file_unit_tb.sv -----
// Testbench for the protection chip register file unit: directed and random bus traffic checked by a predictor.
module protection_chip_register_file_unit_tb;
    import pcrf_pkg::*;

    // Command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Percent of cycles in which each side idles.
    localparam int IDLE_PCT = 30;

    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    // Least number of random accesses queued per region phase.
    localparam int PHASE_ITEMS = 52;

    // Region codes visited by the random phases, extremes included.
    localparam int REGION_ORDER [8] = '{0, 3, 2, 1, 4, 5, 6, 7};

    // Scrambler feedback mode for each region code.
    localparam pcrf_mode_t REGION_MODE [8] = '{MODE_1, MODE_1, MODE_3, MODE_2,
                                               MODE_4, MODE_4, MODE_4, MODE_4};

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data;
    } bus_access_t;

    logic clk;
    logic rst_n;
    logic cfg_we = 1'b0;
    logic [REGION_W-1:0] cfg_wdata = '0;

    pcrf_cmd_if cmd_ch();
    pcrf_rd_if  rd_ch();

    protection_chip_register_file_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rd_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Accesses waiting to be offered, and read bytes still owed by the block.
    bus_access_t       pending_accesses [$];
    logic [BYTE_W-1:0] read_bytes_due [$];

    // Traffic shaping shared between the sequence and the two bus sides.
    bit steady = 1'b0;
    int hold_requests = 0;
    int failures = 0;

    // Predicted register state of the chip.
    logic [REGION_W-1:0] region_m;
    logic [IDX_W-1:0]    index_m;
    logic [BYTE_W-1:0]   latch_m [3];
    logic [DATA_W-1:0]   pair_m;
    logic [FLAG_W-1:0]   flags_m;
    logic [DATA_W-1:0]   scr_m;

    // Clock.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // One scrambler step: rotate, fixed xor, then data bit and flag feedback.
    function automatic logic [DATA_W-1:0] scrambler_next(
        input logic [DATA_W-1:0]   old,
        input logic [FLAG_W-1:0]   f,
        input logic [REGION_W-1:0] region_code,
        input logic [DATA_W-1:0]   wdata,
        input logic [2:0]          bit_sel
    );
        pcrf_mode_t        mode;
        logic [DATA_W-1:0] rot;
        logic [DATA_W-1:0] fb;
        logic              tap;
        mode = REGION_MODE[region_code];
        rot = {old[DATA_W-2:0], old[DATA_W-1]} ^ SCR_XOR;
        tap = (mode == MODE_1 || mode == MODE_3) ? (old[10] ^ old[8]) : (old[7] ^ old[6]);
        fb = '0;
        fb[0] = wdata[bit_sel] ^ old[5] ^ tap;
        fb[10] = f[2];
        case (mode)
            MODE_1:
            begin
                fb[1] = f[0];
                fb[6] = f[1];
                fb[14] = f[3];
            end
            MODE_2, MODE_3:
            begin
                fb[4] = f[0];
                fb[6] = f[1];
                fb[12] = f[3];
            end
            default:
            begin
                fb[3] = f[0];
                fb[8] = f[1];
                fb[14] = f[3];
            end
        endcase
        return rot ^ fb;
    endfunction

    // Byte returned by a read of the currently selected register.
    function automatic logic [BYTE_W-1:0] expected_read_byte();
        logic [BYTE_W-1:0] b;
        case (index_m)
            IDX_LATCH0:  b = (latch_m[0] & 8'hf7) | {4'b0, region_m[0], 3'b0};
            IDX_LATCH1:  b = latch_m[1];
            IDX_LATCH2:  b = {region_m[1], latch_m[2][6:0]};
            IDX_SCRBYTE: b = {scr_m[5], scr_m[2], scr_m[9], scr_m[7],
                              scr_m[10], scr_m[13], scr_m[12], scr_m[15]};
            8'h20, 8'h2c, 8'h31, 8'h32, 8'h33: b = 8'h49;
            8'h24, 8'h25, 8'h27, 8'h28, 8'h2b: b = 8'h41;
            8'h21: b = 8'h47;
            8'h22: b = 8'h53;
            8'h26: b = 8'h7f;
            8'h2a: b = 8'h3e;
            8'h2d: b = 8'hf9;
            8'h2e: b = 8'h0a;
            8'h30: b = 8'h26;
            8'h34: b = 8'h32;
            default: b = '0;
        endcase
        return b;
    endfunction

    // State change caused by a data write to the selected register.
    function automatic void predict_write(input logic [DATA_W-1:0] wdata);
        if (index_m <= IDX_LATCH2)
        begin
            latch_m[index_m[1:0]] = {wdata[6:0], 1'b0};
        end
        else if (index_m == IDX_SHIFT)
        begin
            pair_m = {pair_m[7:0], 8'h00} | wdata;
        end
        else if (index_m == IDX_FLAGS)
        begin
            flags_m = {(pair_m & FLAG_M3) == '0, (pair_m & FLAG_M2) == '0,
                       (pair_m & FLAG_M1) == '0, (pair_m & FLAG_M0) == '0};
        end
        else if ((index_m & IDX_STEP_MASK) == IDX_STEP)
        begin
            scr_m = scrambler_next(scr_m, flags_m, region_m, wdata, index_m[2:0]);
        end
        else if (index_m == IDX_CLEAR)
        begin
            scr_m = '0;
        end
    endfunction

    // Counts a failure; only the first ten are printed.
    function automatic void report_failure(input string detail);
        if (failures < 10)
        begin
            $display("%0t: mismatch: %s", $time, detail);
        end
        failures++;
    endfunction

    // Predictor and checker: reads the result and the command transfers of each edge.
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        logic [BYTE_W-1:0] want;
        if (!rst_n)
        begin
            region_m = '0;
            index_m = '0;
            latch_m[0] = '0;
            latch_m[1] = '0;
            latch_m[2] = '0;
            pair_m = '0;
            flags_m = '0;
            scr_m = '0;
            read_bytes_due.delete();
        end
        else
        begin
            if (rd_ch.valid && rd_ch.ready)
            begin
                if (read_bytes_due.size() == 0)
                begin
                    report_failure($sformatf("read_data %02h with no read pending",
                                             rd_ch.read_data));
                end
                else
                begin
                    want = read_bytes_due.pop_front();
                    if (rd_ch.read_data !== want)
                    begin
                        report_failure($sformatf("read_data expected %02h, got %02h",
                                                 want, rd_ch.read_data));
                    end
                end
            end
            if (cfg_we)
            begin
                region_m = cfg_wdata;
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                case (cmd_ch.command)
                    CMD_SELECT: index_m = cmd_ch.data[IDX_W-1:0];
                    CMD_WRITE:  predict_write(cmd_ch.data);
                    CMD_READ:   read_bytes_due.push_back(expected_read_byte());
                    default:    ;
                endcase
            end
        end
    end

    // Command driver: offers the next pending access, idling at random.
    always @(posedge clk or negedge rst_n)
    begin : command_driver
        bus_access_t acc;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.command <= CMD_SELECT;
            cmd_ch.data <= '0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (pending_accesses.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                acc = pending_accesses.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.command <= acc.command;
                cmd_ch.data <= acc.data;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Read receiver: random stalls plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : read_receiver
        int hold_left;
        int holds_served;
        if (!rst_n)
        begin
            rd_ch.ready <= 1'b0;
            hold_left = 0;
            holds_served = 0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            rd_ch.ready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
            rd_ch.ready <= 1'b0;
        end
        else
        begin
            rd_ch.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    task automatic queue_access(input logic [CMD_W-1:0] command, input logic [DATA_W-1:0] data);
        bus_access_t acc;
        acc.command = command;
        acc.data = data;
        pending_accesses.push_back(acc);
    endtask

    // Write data with a mix of dense, sparse and extreme patterns.
    function automatic logic [DATA_W-1:0] data_pattern();
        logic [DATA_W-1:0] d;
        case ($urandom_range(0, 3))
            0: d = DATA_W'($urandom_range(0, 65535));
            1: d = DATA_W'($urandom & $urandom & $urandom);
            2: d = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: d = DATA_W'($urandom_range(0, 255));
        endcase
        return d;
    endfunction

    // Register index biased toward the ones with an action.
    function automatic logic [IDX_W-1:0] pick_index();
        logic [IDX_W-1:0] idx;
        case ($urandom_range(0, 9))
            0: idx = IDX_W'($urandom_range(0, 2));
            1: idx = IDX_SCRBYTE;
            2: idx = IDX_SHIFT;
            3: idx = IDX_FLAGS;
            4, 5: idx = IDX_STEP | IDX_W'($urandom_range(0, 7));
            6: idx = IDX_CLEAR;
            7, 8: idx = 8'h20 + IDX_W'($urandom_range(0, 20));
            default: idx = IDX_W'($urandom_range(0, 255));
        endcase
        return idx;
    endfunction

    // A select followed by one to four writes, reads or unused commands on that register.
    task automatic queue_burst(output int count);
        int n;
        int roll;
        queue_access(CMD_SELECT, {8'($urandom_range(0, 255)), pick_index()});
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                queue_access(CMD_UNUSED, data_pattern());
            end
            else if (roll < 50)
            begin
                queue_access(CMD_WRITE, data_pattern());
            end
            else
            begin
                queue_access(CMD_READ, data_pattern());
            end
        end
        count = n + 1;
    endtask

    // Region writes happen only with the block idle.
    task automatic set_region(input logic [REGION_W-1:0] code);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every access is taken and every read byte has arrived.
    task automatic wait_quiet();
        while (pending_accesses.size() != 0 || cmd_ch.valid || read_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Main sequence: reset, directed accesses, then random phases per region.
    initial
    begin
        int added;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_SELECT;
        cmd_ch.data = '0;
        rd_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        set_region(3'd7);

        // Latches: shifted store, region bits merged on read, top data bit lost.
        queue_access(CMD_SELECT, 16'h0000);
        queue_access(CMD_READ, 16'h0000);
        queue_access(CMD_WRITE, 16'hffff);
        queue_access(CMD_READ, 16'hffff);
        queue_access(CMD_SELECT, 16'hff01);
        queue_access(CMD_WRITE, 16'h0080);
        queue_access(CMD_READ, 16'h0000);
        queue_access(CMD_SELECT, 16'h0002);
        queue_access(CMD_WRITE, 16'h007f);
        queue_access(CMD_READ, 16'h0000);
        // Pair shift with the whole data word ORed in, then the zero flags.
        queue_access(CMD_SELECT, 16'h0040);
        queue_access(CMD_WRITE, 16'h00a5);
        queue_access(CMD_WRITE, 16'h3c00);
        queue_access(CMD_SELECT, 16'h0048);
        queue_access(CMD_WRITE, 16'h0000);
        // Scrambler step with flags set, read back, then clear.
        queue_access(CMD_SELECT, 16'h0087);
        queue_access(CMD_WRITE, 16'h0080);
        queue_access(CMD_SELECT, 16'h0003);
        queue_access(CMD_READ, 16'h0000);
        queue_access(CMD_SELECT, 16'h00a0);
        queue_access(CMD_WRITE, 16'h0000);
        // Identity byte, unused command and an unlisted index.
        queue_access(CMD_SELECT, 16'h002d);
        queue_access(CMD_READ, 16'h0000);
        queue_access(CMD_UNUSED, 16'hffff);
        queue_access(CMD_SELECT, 16'h0023);
        queue_access(CMD_READ, 16'h0000);
        wait_quiet();

        for (int p = 0; p < 8; p++)
        begin
            steady = (p == 5);
            set_region(REGION_W'(REGION_ORDER[p]));
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                int burst;
                queue_burst(burst);
                added += burst;
            end
            // Long receiver hold-off so the block backs up and stalls its input.
            if (p == 2)
            begin
                hold_requests++;
            end
            wait_quiet();
            steady = 1'b0;
        end

        repeat (6) @(posedge clk);
        if (failures == 0 && read_bytes_due.size() == 0)
        begin
            $display("protection_chip_register_file_unit test passed");
        end
        else
        begin
            $display("protection_chip_register_file_unit test failed");
        end
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #400000;
        $display("protection_chip_register_file_unit test failed");
        $finish;
    end

endmodule

// ----- protection_chip_register_file_unit.f -----
+incdir+rtl
rtl/pcrf_pkg.sv
rtl/pcrf_if.sv
rtl/pcrf_core.sv
rtl/protection_chip_register_file_unit.sv
tb/protection_chip_register_file_unit_tb.sv
